// ===== rtl/core/biq_pkg.sv =====
`default_nettype none

package biq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 14;
    localparam int STATE_W   = 24;
    localparam int PROD_W    = COEF_W + STATE_W;
    // rounded product: product shifted right by the fraction bits
    localparam int RND_W     = PROD_W - COEF_FRAC;
    // headroom for three rounded terms
    localparam int ACC_W     = RND_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_GAIN_2 = 3'd4;

    localparam logic signed [COEF_W-1:0] FF_GAIN_0_RST = 16'sd16384;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       block_end_in;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
        logic                       block_end_out;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FB0,
        S_FB1,
        S_FB2,
        S_FF0,
        S_FF1,
        S_FF2,
        S_FF3
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/biquad_iir_df2_core.sv =====
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_req  (biq_pkg::t_in_req)
// output    out        o_out_valid / i_out_stall o_out_req (biq_pkg::t_out_req)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A request is accepted while idle, then goes through seven steps on the
// single shared 16x24 multiplier (two feedback and three feedforward products,
// each registered and accumulated in the following step).
// Reset is synchronous and active low; it restores the default coefficients
// and clears the history. Any coefficient write also clears the history.
// A result waits in the output register; the last step holds while it is stalled.

module biquad_iir_df2_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  biq_pkg::t_in_req                   i_in_req,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output biq_pkg::t_out_req                  o_out_req,
    input  wire                                i_cfg_we,
    input  wire  [biq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [biq_pkg::COEF_W-1:0]         i_cfg_data
);

    localparam int ACC_W    = biq_pkg::ACC_W;
    localparam int RND_W    = biq_pkg::RND_W;
    localparam int PROD_W   = biq_pkg::PROD_W;
    localparam int STATE_W  = biq_pkg::STATE_W;
    localparam int SAMPLE_W = biq_pkg::SAMPLE_W;
    localparam int COEF_W   = biq_pkg::COEF_W;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (biq_pkg::COEF_FRAC - 1);
    localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    biq_pkg::t_state r_state, n_state;

    logic signed [COEF_W-1:0]  r_b0, r_b1, r_b2, r_a1, r_a2;
    logic signed [STATE_W-1:0] r_w1, r_w2, r_w0;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_clip;
    logic                      r_blk_end;
    logic                      r_out_valid;
    biq_pkg::t_out_req         r_out;

    logic signed [COEF_W-1:0]  w_mul_coef;
    logic signed [STATE_W-1:0] w_mul_val;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_prod_rnd;
    logic signed [RND_W-1:0]   w_rnd;
    logic signed [ACC_W-1:0]   w_rnd_ext;
    logic signed [ACC_W-1:0]   w_sum;
    logic                      w_sub;
    logic                      w_w0_sat;
    logic                      w_y_sat;
    logic signed [STATE_W-1:0] w_w0;
    logic signed [SAMPLE_W-1:0] w_y;
    logic                      w_accept;
    logic                      w_out_free;

    assign w_accept   = i_in_valid && (r_state == biq_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            biq_pkg::S_FB0: begin
                w_mul_coef = r_a1;
                w_mul_val  = r_w1;
            end
            biq_pkg::S_FB1: begin
                w_mul_coef = r_a2;
                w_mul_val  = r_w2;
            end
            biq_pkg::S_FF0: begin
                w_mul_coef = r_b0;
                w_mul_val  = r_w0;
            end
            biq_pkg::S_FF1: begin
                w_mul_coef = r_b1;
                w_mul_val  = r_w1;
            end
            biq_pkg::S_FF2: begin
                w_mul_coef = r_b2;
                w_mul_val  = r_w2;
            end
            default: begin
                w_mul_coef = '0;
                w_mul_val  = '0;
            end
        endcase
    end

    assign w_prod     = PROD_W'(w_mul_coef) * PROD_W'(w_mul_val);
    // round to nearest, ties up: add half then floor-shift
    assign w_prod_rnd = r_prod + RND_HALF;
    assign w_rnd      = w_prod_rnd[biq_pkg::COEF_FRAC +: RND_W];
    assign w_rnd_ext  = {{(ACC_W-RND_W){w_rnd[RND_W-1]}}, w_rnd};
    assign w_sub      = (r_state == biq_pkg::S_FB1) || (r_state == biq_pkg::S_FB2);
    assign w_sum      = w_sub ? (r_acc - w_rnd_ext) : (r_acc + w_rnd_ext);

    // saturate when the target sign bit and the bits above it disagree
    assign w_w0_sat = !((&w_sum[ACC_W-1:STATE_W-1]) || !(|w_sum[ACC_W-1:STATE_W-1]));
    assign w_y_sat  = !((&w_sum[ACC_W-1:SAMPLE_W-1]) || !(|w_sum[ACC_W-1:SAMPLE_W-1]));
    assign w_w0 = w_w0_sat ? (w_sum[ACC_W-1] ? STATE_MIN : STATE_MAX) : w_sum[STATE_W-1:0];
    assign w_y  = w_y_sat ? (w_sum[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX) : w_sum[SAMPLE_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            biq_pkg::S_IDLE: begin
                if (w_accept) n_state = biq_pkg::S_FB0;
            end
            biq_pkg::S_FB0: n_state = biq_pkg::S_FB1;
            biq_pkg::S_FB1: n_state = biq_pkg::S_FB2;
            biq_pkg::S_FB2: n_state = biq_pkg::S_FF0;
            biq_pkg::S_FF0: n_state = biq_pkg::S_FF1;
            biq_pkg::S_FF1: n_state = biq_pkg::S_FF2;
            biq_pkg::S_FF2: n_state = biq_pkg::S_FF3;
            biq_pkg::S_FF3: begin
                if (w_out_free) n_state = biq_pkg::S_IDLE;
            end
            default: n_state = biq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= biq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // coefficients and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= biq_pkg::FF_GAIN_0_RST;
            r_b1 <= '0;
            r_b2 <= '0;
            r_a1 <= '0;
            r_a2 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                biq_pkg::CFG_FF_GAIN_0: r_b0 <= i_cfg_data;
                biq_pkg::CFG_FF_GAIN_1: r_b1 <= i_cfg_data;
                biq_pkg::CFG_FF_GAIN_2: r_b2 <= i_cfg_data;
                biq_pkg::CFG_FB_GAIN_1: r_a1 <= i_cfg_data;
                biq_pkg::CFG_FB_GAIN_2: r_a2 <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_idx == biq_pkg::CFG_FF_GAIN_0 || i_cfg_idx == biq_pkg::CFG_FF_GAIN_1 ||
                i_cfg_idx == biq_pkg::CFG_FF_GAIN_2 || i_cfg_idx == biq_pkg::CFG_FB_GAIN_1 ||
                i_cfg_idx == biq_pkg::CFG_FB_GAIN_2) begin
                r_w1 <= '0;
                r_w2 <= '0;
            end
        end else if (r_state == biq_pkg::S_FF3 && w_out_free) begin
            // advance the history
            r_w2 <= r_w1;
            r_w1 <= r_w0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // hold the last product while the result waits
        if (r_state != biq_pkg::S_FF3) r_prod <= w_prod;
        case (r_state)
            biq_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_acc     <= {{(ACC_W-SAMPLE_W){i_in_req.sample_in[SAMPLE_W-1]}},
                                  i_in_req.sample_in};
                    r_blk_end <= i_in_req.block_end_in;
                    r_clip    <= 1'b0;
                end
            end
            biq_pkg::S_FB1: r_acc <= w_sum;
            biq_pkg::S_FB2: begin
                r_w0   <= w_w0;
                r_clip <= w_w0_sat;
                r_acc  <= '0;
            end
            biq_pkg::S_FF1, biq_pkg::S_FF2: r_acc <= w_sum;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == biq_pkg::S_FF3 && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == biq_pkg::S_FF3 && w_out_free) begin
            r_out.sample_out    <= w_y;
            r_out.clipped       <= r_clip || w_y_sat;
            r_out.block_end_out <= r_blk_end;
        end
    end

    assign o_in_stall  = (r_state != biq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire
